// ----- hw/rtl/ybc_pkg.sv -----
package ybc_pkg;

  // Frame geometry limits
  localparam int unsigned MAX_ROW_PAIRS = 1024;
  localparam int unsigned MAX_ROWS      = 2048;

  // Register widths
  localparam int unsigned PAIRS_W = 11;
  localparam int unsigned ROWS_W  = 12;
  localparam int unsigned PAD_W   = 8;
  localparam int unsigned CFG_W   = 12;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned POS_W   = 11;

  // Register indexes
  localparam logic [IDX_W-1:0] CFG_PAIRS_PER_ROW  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_ROWS_PER_FRAME = 2'd1;
  localparam logic [IDX_W-1:0] CFG_PAD_WORDS      = 2'd2;

  // Register reset values
  localparam logic [PAIRS_W-1:0] PAIRS_RESET = 11'd320;
  localparam logic [ROWS_W-1:0]  ROWS_RESET  = 12'd480;
  localparam logic [PAD_W-1:0]   PAD_RESET   = 8'd0;

  typedef struct packed {
    logic [PAIRS_W-1:0] pairs_per_row;
    logic [ROWS_W-1:0]  rows_per_frame;
    logic [PAD_W-1:0]   pad_words;
  } cfg_t;

  // One accepted pair on its way to the colour stage
  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
    logic       end_of_line;
    logic       end_of_frame;
  } pair_t;

endpackage

// ----- hw/rtl/ybc_if.sv -----
interface ybc_yuyv_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_first;
  logic [7:0] chroma_blue;
  logic [7:0] luma_second;
  logic [7:0] chroma_red;

  modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                  input ready);
  modport sink   (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                  output ready);
endinterface

interface ybc_bgr_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_blue;
  logic [7:0] first_green;
  logic [7:0] first_red;
  logic [7:0] second_blue;
  logic [7:0] second_green;
  logic [7:0] second_red;
  logic       end_of_line;
  logic       end_of_frame;

  modport source (output valid, first_blue, first_green, first_red, second_blue,
                  second_green, second_red, end_of_line, end_of_frame,
                  input ready);
  modport sink   (input valid, first_blue, first_green, first_red, second_blue,
                  second_green, second_red, end_of_line, end_of_frame,
                  output ready);
endinterface

// ----- hw/rtl/ybc_framer.sv -----
module ybc_framer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ybc_pkg::cfg_t cfg_i,
  ybc_yuyv_if.sink      yuyv_i,
  input  logic          stage_ready_i,
  output logic          stage_valid_o,
  output ybc_pkg::pair_t stage_o
);
  import ybc_pkg::*;

  logic [POS_W-1:0]   word_q, word_d;
  logic [POS_W-1:0]   row_q, row_d;
  logic               valid_q, valid_d;
  pair_t              pair_q;
  logic [PAIRS_W-1:0] pairs_eff;
  logic [ROWS_W-1:0]  rows_eff;
  logic [POS_W:0]     row_len;
  logic [POS_W:0]     word_inc;
  logic [POS_W:0]     row_inc;
  logic               accept;
  logic               produce;
  logic               eol;
  logic               eof;

  // Clamp the geometry: zero acts as one, oversize saturates
  always_comb begin
    if (cfg_i.pairs_per_row == '0) begin
      pairs_eff = PAIRS_W'(1);
    end else if (cfg_i.pairs_per_row > PAIRS_W'(MAX_ROW_PAIRS)) begin
      pairs_eff = PAIRS_W'(MAX_ROW_PAIRS);
    end else begin
      pairs_eff = cfg_i.pairs_per_row;
    end
    if (cfg_i.rows_per_frame == '0) begin
      rows_eff = ROWS_W'(1);
    end else if (cfg_i.rows_per_frame > ROWS_W'(MAX_ROWS)) begin
      rows_eff = ROWS_W'(MAX_ROWS);
    end else begin
      rows_eff = cfg_i.rows_per_frame;
    end
  end

  assign row_len  = (POS_W+1)'(pairs_eff) + (POS_W+1)'(cfg_i.pad_words);
  assign word_inc = {1'b0, word_q} + (POS_W+1)'(1);
  assign row_inc  = {1'b0, row_q} + (POS_W+1)'(1);

  assign yuyv_i.ready = !valid_q || stage_ready_i;
  assign accept       = yuyv_i.valid && yuyv_i.ready;
  assign produce      = ({1'b0, word_q} < (POS_W+1)'(pairs_eff));
  assign eol          = ({1'b0, word_q} == (POS_W+1)'(pairs_eff) - (POS_W+1)'(1));
  assign eof          = eol && ({1'b0, row_q} == rows_eff - ROWS_W'(1));

  // Advance word and row positions on every accepted item, padding included
  always_comb begin
    word_d  = word_q;
    row_d   = row_q;
    valid_d = valid_q;
    if (accept) begin
      valid_d = produce;
      if (word_inc >= row_len) begin
        word_d = '0;
        if (row_inc >= (POS_W+1)'(rows_eff)) begin
          row_d = '0;
        end else begin
          row_d = row_inc[POS_W-1:0];
        end
      end else begin
        word_d = word_inc[POS_W-1:0];
      end
    end else if (stage_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q  <= '0;
      row_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      word_q  <= word_d;
      row_q   <= row_d;
      valid_q <= valid_d;
    end
  end

  // Hold the item in the input register
  always_ff @(posedge clk_i) begin
    if (accept && produce) begin
      pair_q.luma_first   <= yuyv_i.luma_first;
      pair_q.chroma_blue  <= yuyv_i.chroma_blue;
      pair_q.luma_second  <= yuyv_i.luma_second;
      pair_q.chroma_red   <= yuyv_i.chroma_red;
      pair_q.end_of_line  <= eol;
      pair_q.end_of_frame <= eof;
    end
  end

  assign stage_valid_o = valid_q;
  assign stage_o       = pair_q;

endmodule

// ----- hw/rtl/ybc_colour.sv -----
module ybc_colour (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           stage_valid_i,
  input  ybc_pkg::pair_t stage_i,
  output logic           stage_ready_o,
  ybc_bgr_if.source      bgr_o
);
  import ybc_pkg::*;

  logic signed [7:0]  du;
  logic signed [7:0]  dv;
  logic signed [15:0] blue_prod;
  logic signed [11:0] green_sum;
  logic signed [9:0]  red_prod;
  logic signed [9:0]  off_b;
  logic signed [8:0]  off_g;
  logic signed [8:0]  off_r;
  logic signed [10:0] y0;
  logic signed [10:0] y1;
  logic               valid_q;
  logic               take;
  logic [7:0]         b0_d, g0_d, r0_d, b1_d, g1_d, r1_d;
  logic [7:0]         b0_q, g0_q, r0_q, b1_q, g1_q, r1_q;
  logic               eol_q, eof_q;

  function automatic logic [7:0] clip8(input logic signed [10:0] v);
    if (v < 0) begin
      return 8'd0;
    end else if (v > 11'sd255) begin
      return 8'hFF;
    end else begin
      return v[7:0];
    end
  endfunction

  // Remove the chroma offset by flipping the top bit
  assign du = $signed({~stage_i.chroma_blue[7], stage_i.chroma_blue[6:0]});
  assign dv = $signed({~stage_i.chroma_red[7], stage_i.chroma_red[6:0]});

  // Chroma terms: 129*du, 3*du + 6*dv and 3*dv, floored by arithmetic shifts
  assign blue_prod = (16'(du) <<< 7) + 16'(du);
  assign green_sum = (12'(du) <<< 1) + 12'(du) + (12'(dv) <<< 2) + (12'(dv) <<< 1);
  assign red_prod  = (10'(dv) <<< 1) + 10'(dv);
  assign off_b     = 10'(blue_prod >>> 6);
  assign off_g     = 9'(green_sum >>> 3);
  assign off_r     = 9'(red_prod >>> 1);

  assign y0 = $signed({3'b000, stage_i.luma_first});
  assign y1 = $signed({3'b000, stage_i.luma_second});

  assign b0_d = clip8(y0 + 11'(off_b));
  assign g0_d = clip8(y0 - 11'(off_g));
  assign r0_d = clip8(y0 + 11'(off_r));
  assign b1_d = clip8(y1 + 11'(off_b));
  assign g1_d = clip8(y1 - 11'(off_g));
  assign r1_d = clip8(y1 + 11'(off_r));

  assign stage_ready_o = !valid_q || bgr_o.ready;
  assign take          = stage_valid_i && stage_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (stage_ready_o) begin
      valid_q <= stage_valid_i;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (take) begin
      b0_q  <= b0_d;
      g0_q  <= g0_d;
      r0_q  <= r0_d;
      b1_q  <= b1_d;
      g1_q  <= g1_d;
      r1_q  <= r1_d;
      eol_q <= stage_i.end_of_line;
      eof_q <= stage_i.end_of_frame;
    end
  end

  assign bgr_o.valid        = valid_q;
  assign bgr_o.first_blue   = b0_q;
  assign bgr_o.first_green  = g0_q;
  assign bgr_o.first_red    = r0_q;
  assign bgr_o.second_blue  = b1_q;
  assign bgr_o.second_green = g1_q;
  assign bgr_o.second_red   = r1_q;
  assign bgr_o.end_of_line  = eol_q;
  assign bgr_o.end_of_frame = eof_q;

endmodule

// ----- hw/rtl/yuyv_to_bgr24_converter_core.sv -----
// A converted item passes through the input register and then the result register.
// Throughput: one item per cycle while the output is ready; an input register and a result register
// each move on when the stage after them takes their item.
// Row padding words are accepted at the same rate and give no result.
// Reset clears the word and row counters and the pipeline, and loads the
// defaults of 320 pairs per row, 480 rows per frame and no padding.
module yuyv_to_bgr24_converter_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ybc_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [ybc_pkg::CFG_W-1:0] cfg_data_i,
  ybc_yuyv_if.sink                  yuyv_i,
  ybc_bgr_if.source                 bgr_o
);
  import ybc_pkg::*;

  cfg_t  cfg_q;
  logic  stage_valid;
  logic  stage_ready;
  pair_t stage;

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pairs_per_row  <= PAIRS_RESET;
      cfg_q.rows_per_frame <= ROWS_RESET;
      cfg_q.pad_words      <= PAD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PAIRS_PER_ROW:  cfg_q.pairs_per_row  <= cfg_data_i[PAIRS_W-1:0];
        CFG_ROWS_PER_FRAME: cfg_q.rows_per_frame <= cfg_data_i[ROWS_W-1:0];
        CFG_PAD_WORDS:      cfg_q.pad_words      <= cfg_data_i[PAD_W-1:0];
        default: ;
      endcase
    end
  end

  ybc_framer u_framer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .yuyv_i        (yuyv_i),
    .stage_ready_i (stage_ready),
    .stage_valid_o (stage_valid),
    .stage_o       (stage)
  );

  ybc_colour u_colour (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_valid_i (stage_valid),
    .stage_i       (stage),
    .stage_ready_o (stage_ready),
    .bgr_o         (bgr_o)
  );

endmodule
